// File: rtl/fragmented_sparse_array_defines.svh
// Assertion macros for the RTL file that checks itself.
`ifndef FRAGMENTED_SPARSE_ARRAY_DEFINES_SVH
`define FRAGMENTED_SPARSE_ARRAY_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define FSA_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent that implies a consequent in the same cycle.
`define FSA_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/fsa_pkg.sv
package fsa_pkg;

    // Field and configuration widths
    localparam int CFG_W     = 5;
    localparam int KEY_W     = 32;
    localparam int IDX_W     = 2 * CFG_W;
    localparam int Q_W       = CFG_W;
    localparam int CELL_W    = KEY_W + 1;
    localparam int CFG_IDX_W = 2;

    // Operation codes
    typedef enum logic [1:0] {
        OP_SET = 2'd0,
        OP_GET = 2'd1,
        OP_DEL = 2'd2,
        OP_NOP = 2'd3
    } op_t;

    // Response status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE  = 2'd1;
    localparam logic [1:0] ST_UNUSED = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FRAG_TOTAL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAG_LEN      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_MARKER = 2'd2;

    // Configuration reset values
    localparam logic [CFG_W-1:0] FRAG_TOTAL_RST    = 5'd16;
    localparam logic [CFG_W-1:0] FRAG_LEN_RST      = 5'd16;
    localparam logic [KEY_W-1:0] UNUSED_MARKER_RST = 32'h8000_0000;

    typedef struct packed {
        op_t                op;
        logic signed [31:0] cell_index;
        logic signed [31:0] key_value;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic [8:0]         occupied_total;
        logic [4:0]         active_fragments;
    } rsp_t;

    // Memory port controls from the sequencer to the store
    typedef struct packed {
        logic rd_en;
        logic cell_we;
        logic fill_we;
    } mem_ctl_t;

endpackage

// File: rtl/fsa_divider.sv
module fsa_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [fsa_pkg::IDX_W-1:0]   dividend,
    input  logic [fsa_pkg::CFG_W-1:0]   divisor,
    output logic                        done,
    output logic [fsa_pkg::Q_W-1:0]     quotient,
    output logic [fsa_pkg::CFG_W-1:0]   remainder
);
    import fsa_pkg::*;

    localparam int BIT_W = $clog2(Q_W);

    logic             busy_reg;
    logic             done_reg;
    logic [BIT_W-1:0] bit_reg;
    logic [IDX_W-1:0] rem_reg;
    logic [CFG_W-1:0] div_reg;
    logic [Q_W-1:0]   q_reg;
    logic [IDX_W-1:0] trial;
    logic             fits;

    // Restoring step: compare against the divisor shifted to the current bit
    always_comb
    begin
        trial = IDX_W'(div_reg) << bit_reg;
        fits  = (rem_reg >= trial);
    end

    // Step control: one quotient bit per cycle, most significant first
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                bit_reg  <= BIT_W'(Q_W - 1);
            end
            else if (busy_reg)
            begin
                if (bit_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    bit_reg <= bit_reg - 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder and quotient bits
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            div_reg <= divisor;
            q_reg   <= '0;
        end
        else if (busy_reg && fits)
        begin
            rem_reg        <= rem_reg - trial;
            q_reg[bit_reg] <= 1'b1;
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = CFG_W'(rem_reg);

endmodule

// File: rtl/fsa_store.sv
module fsa_store #(
    parameter int MAX_FRAGMENTS = 16,
    parameter int MAX_FRAG_LEN  = 16,
    localparam int CELL_DEPTH   = MAX_FRAGMENTS * MAX_FRAG_LEN,
    localparam int AW           = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1,
    localparam int FW           = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1,
    localparam int FILL_W       = $clog2(MAX_FRAG_LEN + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fsa_pkg::mem_ctl_t            ctl,
    input  logic [AW-1:0]                cell_addr,
    input  logic [FW-1:0]                frag_addr,
    input  logic [fsa_pkg::CELL_W-1:0]   cell_wdata,
    input  logic [FILL_W-1:0]            fill_wdata,
    output logic [fsa_pkg::CELL_W-1:0]   cell_rdata,
    output logic [FILL_W-1:0]            fill_rdata,
    output logic                         clearing
);
    import fsa_pkg::*;

    // Cell word: occupied flag over the key
    logic [CELL_W-1:0] cell_mem [CELL_DEPTH];
    logic [FILL_W-1:0] fill_mem [MAX_FRAGMENTS];

    logic              clr_busy_reg;
    logic [AW-1:0]     clr_addr_reg;
    logic              clr_fill;
    logic [CELL_W-1:0] cell_rdata_reg;
    logic [FILL_W-1:0] fill_rdata_reg;

    assign clr_fill = (32'(clr_addr_reg) < MAX_FRAGMENTS);

    // Sweep both memories once after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == AW'(CELL_DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            else
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // Write ports: the sweep has priority over write-back
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            cell_mem[clr_addr_reg] <= '0;
            if (clr_fill)
            begin
                fill_mem[FW'(clr_addr_reg)] <= '0;
            end
        end
        else
        begin
            if (ctl.cell_we)
            begin
                cell_mem[cell_addr] <= cell_wdata;
            end
            if (ctl.fill_we)
            begin
                fill_mem[frag_addr] <= fill_wdata;
            end
        end
    end

    // Registered read ports; data holds until the next read
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            cell_rdata_reg <= cell_mem[cell_addr];
            fill_rdata_reg <= fill_mem[frag_addr];
        end
    end

    assign cell_rdata = cell_rdata_reg;
    assign fill_rdata = fill_rdata_reg;
    assign clearing   = clr_busy_reg;

endmodule

// File: rtl/fragmented_sparse_array.sv
// Channel   Dir  Handshake              Payload
// cfg       in   cfg_valid / cfg_ready  cfg_index, cfg_data
// req       in   req_valid / req_ready  fsa_pkg::req_t
// rsp       out  rsp_valid / rsp_ready  fsa_pkg::rsp_t
//
// An in-range request is accepted, split by the bit-serial divider (one quotient
// bit per cycle), read from memory and then written back. Out-of-range and no-op
// requests skip the divider and the read and go straight to write-back.
// After reset a clearing pass over all MAX_FRAGMENTS * MAX_FRAG_LEN cells holds
// req_ready low; configuration writes are taken throughout.
// A response still waiting on rsp_ready stalls write-back of the next request.
`include "fragmented_sparse_array_defines.svh"

module fragmented_sparse_array #(
    parameter int MAX_FRAGMENTS = 16,
    parameter int MAX_FRAG_LEN  = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                    cfg_data,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  fsa_pkg::req_t                  req,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output fsa_pkg::rsp_t                  rsp
);
    import fsa_pkg::*;

    localparam int CELL_DEPTH = MAX_FRAGMENTS * MAX_FRAG_LEN;
    localparam int AW         = (CELL_DEPTH > 1) ? $clog2(CELL_DEPTH) : 1;
    localparam int FW         = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
    localparam int FILL_W     = $clog2(MAX_FRAG_LEN + 1);
    localparam int OCC_W      = $clog2(CELL_DEPTH + 1);
    localparam int ACT_W      = $clog2(MAX_FRAGMENTS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_MOD
    } state_t;

    // Configuration
    logic [CFG_W-1:0]  frag_total_reg;
    logic [CFG_W-1:0]  frag_len_reg;
    logic [KEY_W-1:0]  marker_reg;

    // Sequencer and counters
    state_t            state_reg, state_next;
    op_t               op_reg;
    logic              skip_reg;
    logic [1:0]        skip_status_reg;
    logic [OCC_W-1:0]  occ_reg, occ_next;
    logic [ACT_W-1:0]  act_reg, act_next;
    logic              rsp_valid_reg, rsp_valid_next;
    rsp_t              rsp_reg, rsp_next;

    // Item payload
    logic [KEY_W-1:0]  key_reg;
    logic [AW-1:0]     addr_reg;
    logic [FW-1:0]     frag_reg;

    // Index split and range check
    logic [CFG_W-1:0]  nfrag_eff;
    logic [CFG_W-1:0]  flen_eff;
    logic [IDX_W-1:0]  capacity;
    logic              range_bad;
    logic              req_fire;
    logic              div_start;
    logic              div_done;
    logic [Q_W-1:0]    div_q;
    logic [CFG_W-1:0]  div_r;
    logic [AW-1:0]     addr_calc;

    // Memory ports
    mem_ctl_t          mem_ctl;
    logic [AW-1:0]     mem_addr;
    logic [FW-1:0]     mem_frag;
    logic [CELL_W-1:0] cell_wdata;
    logic [FILL_W-1:0] fill_wdata;
    logic [CELL_W-1:0] cell_rdata;
    logic [FILL_W-1:0] fill_rdata;
    logic              clearing;

    // Write-back
    logic              commit;
    logic              cell_occ;
    logic [1:0]        status_calc;
    logic [KEY_W-1:0]  read_calc;

    // Clamp configuration to the built storage
    always_comb
    begin
        nfrag_eff = (32'(frag_total_reg) > MAX_FRAGMENTS) ? CFG_W'(MAX_FRAGMENTS)
                                                           : frag_total_reg;
        flen_eff  = (32'(frag_len_reg) > MAX_FRAG_LEN) ? CFG_W'(MAX_FRAG_LEN)
                                                        : frag_len_reg;
        capacity  = IDX_W'(nfrag_eff) * IDX_W'(flen_eff);
        range_bad = req.cell_index[31] || ($unsigned(req.cell_index) >= 32'(capacity));
    end

    assign cfg_ready = 1'b1;
    assign req_ready = (state_reg == S_IDLE) && !clearing;
    assign req_fire  = req_valid && req_ready;
    assign div_start = req_fire && !range_bad && (req.op != OP_NOP);
    assign addr_calc = AW'(32'(div_q) * 32'(MAX_FRAG_LEN) + 32'(div_r));

    fsa_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (IDX_W'(req.cell_index)),
        .divisor   (flen_eff),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    fsa_store #(
        .MAX_FRAGMENTS (MAX_FRAGMENTS),
        .MAX_FRAG_LEN  (MAX_FRAG_LEN)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (mem_ctl),
        .cell_addr  (mem_addr),
        .frag_addr  (mem_frag),
        .cell_wdata (cell_wdata),
        .fill_wdata (fill_wdata),
        .cell_rdata (cell_rdata),
        .fill_rdata (fill_rdata),
        .clearing   (clearing)
    );

    // Read when the split is ready, write back from the latched address
    assign commit   = (state_reg == S_MOD) && (!rsp_valid_reg || rsp_ready);
    assign cell_occ = cell_rdata[KEY_W];
    assign mem_addr = (state_reg == S_MOD) ? addr_reg : addr_calc;
    assign mem_frag = (state_reg == S_MOD) ? frag_reg : FW'(div_q);

    // Modify the cell and counters and form status and read value for the held request
    always_comb
    begin
        mem_ctl.rd_en   = (state_reg == S_DIV) && div_done;
        mem_ctl.cell_we = 1'b0;
        mem_ctl.fill_we = 1'b0;
        cell_wdata      = {1'b1, key_reg};
        fill_wdata      = fill_rdata;
        status_calc     = ST_OK;
        read_calc       = '0;
        occ_next        = occ_reg;
        act_next        = act_reg;
        if (skip_reg)
        begin
            status_calc = skip_status_reg;
        end
        else
        begin
            unique case (op_reg)
                OP_SET:
                begin
                    mem_ctl.cell_we = commit;
                    if (!cell_occ)
                    begin
                        mem_ctl.fill_we = commit;
                        if (32'(fill_rdata) < MAX_FRAG_LEN)
                        begin
                            fill_wdata = fill_rdata + 1'b1;
                        end
                        if ((fill_rdata == '0) && (32'(act_reg) < MAX_FRAGMENTS))
                        begin
                            act_next = act_reg + 1'b1;
                        end
                        if (32'(occ_reg) < CELL_DEPTH)
                        begin
                            occ_next = occ_reg + 1'b1;
                        end
                    end
                end
                OP_GET:
                begin
                    read_calc = cell_occ ? cell_rdata[KEY_W-1:0] : marker_reg;
                end
                OP_DEL:
                begin
                    if (!cell_occ)
                    begin
                        status_calc = ST_UNUSED;
                    end
                    else
                    begin
                        mem_ctl.cell_we = commit;
                        cell_wdata      = {1'b0, marker_reg};
                        if (fill_rdata != '0)
                        begin
                            mem_ctl.fill_we = commit;
                            fill_wdata      = fill_rdata - 1'b1;
                            if ((fill_rdata == FILL_W'(1)) && (act_reg != '0))
                            begin
                                act_next = act_reg - 1'b1;
                            end
                        end
                        if (occ_reg != '0)
                        begin
                            occ_next = occ_reg - 1'b1;
                        end
                    end
                end
                OP_NOP:
                begin
                    status_calc = ST_OK;
                end
            endcase
        end
    end

    // Next state and response register
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (div_start)
                begin
                    state_next = S_DIV;
                end
                else if (req_fire)
                begin
                    state_next = S_MOD;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_MOD;
                end
            end
            S_MOD:
            begin
                if (commit)
                begin
                    state_next                = S_IDLE;
                    rsp_valid_next            = 1'b1;
                    rsp_next.status           = status_calc;
                    rsp_next.read_value       = read_calc;
                    rsp_next.occupied_total   = 9'(occ_next);
                    rsp_next.active_fragments = 5'(act_next);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state, counters, configuration and response
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= OP_NOP;
            skip_reg        <= 1'b0;
            skip_status_reg <= ST_OK;
            occ_reg         <= '0;
            act_reg         <= '0;
            rsp_valid_reg   <= 1'b0;
            rsp_reg         <= '0;
            frag_total_reg  <= FRAG_TOTAL_RST;
            frag_len_reg    <= FRAG_LEN_RST;
            marker_reg      <= UNUSED_MARKER_RST;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
            if (req_fire)
            begin
                op_reg          <= req.op;
                skip_reg        <= !div_start;
                skip_status_reg <= (req.op != OP_NOP && range_bad) ? ST_RANGE : ST_OK;
            end
            if (commit)
            begin
                occ_reg <= occ_next;
                act_reg <= act_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_FRAG_TOTAL:    frag_total_reg <= cfg_data[CFG_W-1:0];
                    CFG_FRAG_LEN:      frag_len_reg   <= cfg_data[CFG_W-1:0];
                    CFG_UNUSED_MARKER: marker_reg     <= cfg_data;
                    default:           marker_reg     <= marker_reg;
                endcase
            end
        end
    end

    // Hold key and cell address for write-back
    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            key_reg <= req.key_value;
        end
        if (mem_ctl.rd_en)
        begin
            addr_reg <= addr_calc;
            frag_reg <= FW'(div_q);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `FSA_ASSERT_HOLDS(a_active_le_occupied, 32'(act_reg) <= 32'(occ_reg), "active fragments exceed occupied cells")
    `FSA_ASSERT_IMPLIES(a_div_done_in_divide, div_done, state_reg == S_DIV, "divider finished outside the divide state")
    `FSA_ASSERT_IMPLIES(a_split_in_range, div_done, (div_q < nfrag_eff) && (div_r < flen_eff), "index split fell outside the configured fragments")

endmodule

// File: tb/sv/fsa_checker.sv
module fsa_checker #(
    parameter int MAX_FRAGMENTS = 16,
    parameter int MAX_FRAG_LEN  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [fsa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    input  logic                          req_valid,
    input  logic                          req_ready,
    input  fsa_pkg::req_t                 req,
    input  logic                          rsp_valid,
    input  logic                          rsp_ready,
    input  fsa_pkg::rsp_t                 rsp,
    output int                            mismatch_count,
    output int                            pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import fsa_pkg::*;

    localparam int DEPTH = MAX_FRAGMENTS * MAX_FRAG_LEN;

    // Mirrored registers
    logic [CFG_W-1:0] frag_total_q;
    logic [CFG_W-1:0] frag_len_q;
    logic [31:0]      marker_q;

    // Mirrored array contents and counters
    logic [31:0] key_mem [DEPTH];
    logic        held [DEPTH];
    int unsigned fill [MAX_FRAGMENTS];
    int unsigned held_count;
    int unsigned active_count;

    // Responses predicted for accepted requests, oldest first
    rsp_t predicted_rsp_q [$];

    task automatic report_error(input string msg);
        $display("checker: %s", msg);
        mismatch_count++;
    endtask

    // Apply one request to the mirror and return the response it must produce
    function automatic rsp_t apply_request(input req_t r);
        int unsigned nfrag;
        int unsigned flen;
        int unsigned cap;
        int unsigned idx;
        int unsigned frag;
        int unsigned off;
        int unsigned addr;
        rsp_t res;
        nfrag = (frag_total_q > MAX_FRAGMENTS) ? MAX_FRAGMENTS : frag_total_q;
        flen  = (frag_len_q > MAX_FRAG_LEN) ? MAX_FRAG_LEN : frag_len_q;
        cap   = nfrag * flen;
        idx   = r.cell_index;
        res.status     = ST_OK;
        res.read_value = '0;
        if (r.op != OP_NOP)
        begin
            if (r.cell_index[31] || flen == 0 || idx >= cap)
            begin
                res.status = ST_RANGE;
            end
            else
            begin
                // cells keep their storage slot even when the split changes
                frag = idx / flen;
                off  = idx % flen;
                addr = frag * MAX_FRAG_LEN + off;
                if (frag >= MAX_FRAGMENTS || addr >= DEPTH)
                begin
                    res.status = ST_RANGE;
                end
                else if (r.op == OP_SET)
                begin
                    if (!held[addr])
                    begin
                        held[addr] = 1'b1;
                        if (fill[frag] == 0 && active_count < MAX_FRAGMENTS)
                            active_count++;
                        if (fill[frag] < MAX_FRAG_LEN)
                            fill[frag]++;
                        if (held_count < DEPTH)
                            held_count++;
                    end
                    key_mem[addr] = r.key_value;
                end
                else if (r.op == OP_GET)
                begin
                    res.read_value = held[addr] ? key_mem[addr] : marker_q;
                end
                else if (!held[addr])
                begin
                    res.status = ST_UNUSED;
                end
                else
                begin
                    // free the cell, retire the fragment when it empties
                    held[addr]    = 1'b0;
                    key_mem[addr] = marker_q;
                    if (fill[frag] > 0)
                    begin
                        fill[frag]--;
                        if (fill[frag] == 0 && active_count > 0)
                            active_count--;
                    end
                    if (held_count > 0)
                        held_count--;
                end
            end
        end
        res.occupied_total   = held_count[8:0];
        res.active_fragments = active_count[4:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            frag_total_q = FRAG_TOTAL_RST;
            frag_len_q   = FRAG_LEN_RST;
            marker_q     = UNUSED_MARKER_RST;
            for (int i = 0; i < DEPTH; i++)
                held[i] = 1'b0;
            for (int i = 0; i < MAX_FRAGMENTS; i++)
                fill[i] = 0;
            held_count   = 0;
            active_count = 0;
            predicted_rsp_q.delete();
            mismatch_count = 0;
            pending        = 0;
        end
        else
        begin
            // compare the response with the oldest prediction
            if (rsp_valid && rsp_ready)
            begin
                if (predicted_rsp_q.size() == 0)
                begin
                    report_error($sformatf("response with none outstanding: status %0d",
                                           rsp.status));
                end
                else
                begin
                    want = predicted_rsp_q.pop_front();
                    if (rsp.status !== want.status)
                        report_error($sformatf("status %0d, expected %0d",
                                               rsp.status, want.status));
                    if (rsp.read_value !== want.read_value)
                        report_error($sformatf("read_value %h, expected %h",
                                               rsp.read_value, want.read_value));
                    if (rsp.occupied_total !== want.occupied_total)
                        report_error($sformatf("occupied_total %0d, expected %0d",
                                               rsp.occupied_total, want.occupied_total));
                    if (rsp.active_fragments !== want.active_fragments)
                        report_error($sformatf("active_fragments %0d, expected %0d",
                                               rsp.active_fragments, want.active_fragments));
                end
            end

            // track register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_FRAG_TOTAL:    frag_total_q = cfg_data[CFG_W-1:0];
                    CFG_FRAG_LEN:      frag_len_q   = cfg_data[CFG_W-1:0];
                    CFG_UNUSED_MARKER: marker_q     = cfg_data;
                    default:           ;
                endcase
            end

            // predict each accepted request
            if (req_valid && req_ready)
                predicted_rsp_q.push_back(apply_request(req));

            pending = predicted_rsp_q.size();
        end
    end

endmodule

// File: tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import fsa_pkg::*;

    localparam int MAX_FRAGMENTS = 16;
    localparam int MAX_FRAG_LEN  = 16;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int DRAIN_CYCLES  = 20;

    // Write index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

    // Idle mixes switch over at these request counts
    localparam int MIX_SWAP_AT = 340;
    localparam int MIX_NONE_AT = 680;

    // Register settings walked through after the directed part
    localparam int PHASES              = 9;
    localparam int FILL_PHASE          = 0;
    localparam int FIRST_RANDOM_MARKER = 4;

    int unsigned phase_total   [PHASES] = '{16, 16, 0, 16, 31, 1, 5, 16, 11};
    int unsigned phase_len     [PHASES] = '{16, 16, 16, 0, 31, 1, 3, 7, 16};
    int unsigned phase_set_pct [PHASES] = '{96, 10, 40, 40, 30, 60, 50, 45, 40};
    int unsigned phase_items   [PHASES] = '{300, 100, 30, 30, 120, 40, 130, 130, 130};
    logic [31:0] phase_marker  [PHASES] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                                            32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 32'h0,
                                            32'h0};

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data  = '0;
    logic                 req_valid = 1'b0;
    logic                 req_ready;
    req_t                 req       = '0;
    logic                 rsp_valid;
    logic                 rsp_ready = 1'b0;
    rsp_t                 rsp;

    int          mismatch_count;
    int          pending_rsp;
    int unsigned items_sent    = 0;
    int unsigned send_idle_pct = 14;
    int unsigned rsp_idle_pct  = 87;
    int unsigned cycle_count   = 0;

    fragmented_sparse_array #(
        .MAX_FRAGMENTS (MAX_FRAGMENTS),
        .MAX_FRAG_LEN  (MAX_FRAG_LEN)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    fsa_checker #(
        .MAX_FRAGMENTS (MAX_FRAGMENTS),
        .MAX_FRAG_LEN  (MAX_FRAG_LEN)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req            (req),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .rsp            (rsp),
        .mismatch_count (mismatch_count),
        .pending        (pending_rsp)
    );

    always #5 clk = ~clk;

    // Stall the response side at random
    always @(negedge clk)
    begin
        rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Present one request and hold it until taken; valid stays high on return
    task automatic send_request(input op_t kind, input logic [31:0] idx,
                                input logic [31:0] key);
        if (items_sent < MIX_SWAP_AT)
        begin
            send_idle_pct = 14;
            rsp_idle_pct  = 87;
        end
        else if (items_sent < MIX_NONE_AT)
        begin
            send_idle_pct = 87;
            rsp_idle_pct  = 14;
        end
        else
        begin
            send_idle_pct = 0;
            rsp_idle_pct  = 0;
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= '{op: kind, cell_index: idx, key_value: key};
        do @(posedge clk); while (!req_ready);
        @(negedge clk);
        items_sent++;
    endtask

    // Present one register write; valid stays high on return
    task automatic write_reg(input logic [CFG_IDX_W-1:0] which, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
    endtask

    initial
    begin
        int unsigned nfrag;
        int unsigned flen;
        int unsigned cap;
        int unsigned sweep_pos;
        int unsigned roll;
        int unsigned set_pct;
        logic [31:0] idx;
        logic [31:0] marker;
        op_t         kind;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed requests under the reset settings
        send_request(OP_SET, 32'd0, 32'h7FFF_FFFF);
        send_request(OP_GET, 32'd0, 32'h0);
        send_request(OP_SET, 32'd255, 32'h8000_0000);
        send_request(OP_GET, 32'd255, 32'hFFFF_FFFF);
        send_request(OP_SET, 32'd0, 32'hFFFF_FFFF);        // overwrite held cell
        send_request(OP_GET, 32'd0, 32'h0);
        send_request(OP_SET, 32'd256, 32'h1234_5678);      // one past the end
        send_request(OP_GET, 32'hFFFF_FFFF, 32'h0);        // negative index
        send_request(OP_DEL, 32'h8000_0000, 32'h0);        // most negative index
        send_request(OP_GET, 32'h7FFF_FFFF, 32'h0);        // largest positive index
        send_request(OP_GET, 32'd17, 32'h0);               // inactive fragment
        send_request(OP_DEL, 32'd17, 32'h0);               // free cell
        send_request(OP_DEL, 32'd0, 32'h0);                // empties fragment 0
        send_request(OP_GET, 32'd0, 32'h0);
        send_request(OP_DEL, 32'd255, 32'h0);
        send_request(OP_NOP, 32'd5, 32'hDEAD_BEEF);
        send_request(OP_SET, 32'd16, 32'h5555_5555);
        send_request(OP_SET, 32'd31, 32'hAAAA_AAAA);
        send_request(OP_GET, 32'd31, 32'h0);
        send_request(OP_DEL, 32'd16, 32'h0);

        sweep_pos = 0;
        for (int p = 0; p < PHASES; p++)
        begin
            // drain before touching the registers
            req_valid <= 1'b0;
            wait (pending_rsp == 0);
            @(negedge clk);

            marker = (p >= FIRST_RANDOM_MARKER) ? $urandom() : phase_marker[p];
            write_reg(CFG_FRAG_TOTAL, ($urandom() & 32'hFFFF_FFE0) | phase_total[p]);
            write_reg(CFG_FRAG_LEN, ($urandom() & 32'hFFFF_FFE0) | phase_len[p]);
            write_reg(CFG_UNUSED_MARKER, marker);
            if (p == FIRST_RANDOM_MARKER)
                write_reg(CFG_SPARE_INDEX, $urandom());
            cfg_valid <= 1'b0;

            nfrag   = (phase_total[p] > MAX_FRAGMENTS) ? MAX_FRAGMENTS : phase_total[p];
            flen    = (phase_len[p] > MAX_FRAG_LEN) ? MAX_FRAG_LEN : phase_len[p];
            cap     = nfrag * flen;
            set_pct = phase_set_pct[p];

            for (int n = 0; n < phase_items[p]; n++)
            begin
                roll = $urandom_range(99);
                if (p == FILL_PHASE && roll < 95)
                begin
                    // walk every cell in order to fill the array
                    kind = OP_SET;
                    idx  = sweep_pos % cap;
                    sweep_pos++;
                end
                else
                begin
                    if (roll < 2)
                        kind = OP_NOP;
                    else if (roll < 2 + set_pct)
                        kind = OP_SET;
                    else if (roll < 2 + set_pct + (98 - set_pct) / 2)
                        kind = OP_GET;
                    else
                        kind = OP_DEL;
                    // mostly in range, some at the edge, some anywhere
                    roll = $urandom_range(99);
                    if (cap != 0 && roll < 80)
                        idx = $urandom_range(cap - 1);
                    else if (roll < 90)
                        idx = cap + $urandom_range(2) - 1;
                    else
                        idx = $urandom();
                end
                send_request(kind, idx, $urandom());
            end
        end

        req_valid <= 1'b0;
        wait (pending_rsp == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
